// ===== design/lav_pkg.sv =====
// shared types, constants and helper functions for the look-at view matrix block
package lav_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int OUT_W       = 32;
  localparam int MAG_W       = 64;
  localparam int FRAC_W      = 30;
  localparam int ADDR_W      = 5;
  localparam int NUM_REGS    = 6;

  // normalize unit depth: max, msb position, scale, squares, sum, then the iterations
  localparam int PRE_STAGES  = 5;
  localparam int SQRT_STEPS  = 32;
  localparam int DIV_STEPS   = 31;
  localparam int UNIT_LAT    = PRE_STAGES + SQRT_STEPS + DIV_STEPS + 1;
  localparam int PIPE_DEPTH  = 1 + UNIT_LAT + 2 + UNIT_LAT + 3 + 3;

  localparam logic [2:0] REG_EYE_X = 3'd0;
  localparam logic [2:0] REG_EYE_Y = 3'd1;
  localparam logic [2:0] REG_EYE_Z = 3'd2;
  localparam logic [2:0] REG_UP_X  = 3'd3;
  localparam logic [2:0] REG_UP_Y  = 3'd4;
  localparam logic [2:0] REG_UP_Z  = 3'd5;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [OUT_W-1:0]       out_t;
  typedef logic [MAG_W-1:0]              mag_t;

  localparam coord_t REG_RESET [NUM_REGS] = '{
    coord_t'(0), coord_t'(0), coord_t'(196608),
    coord_t'(0), coord_t'(65536), coord_t'(0)
  };

  typedef struct packed {
    coord_t target_x;
    coord_t target_y;
    coord_t target_z;
  } target_t;

  typedef struct packed {
    out_t right_x;
    out_t right_y;
    out_t right_z;
    out_t camera_up_x;
    out_t camera_up_y;
    out_t camera_up_z;
    out_t forward_x;
    out_t forward_y;
    out_t forward_z;
    out_t shift_x;
    out_t shift_y;
    out_t shift_z;
  } matrix_t;

  function automatic mag_t abs_mag(input logic signed [MAG_W:0] v);
    return v[MAG_W] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  function automatic mag_t max3(input mag_t a, input mag_t b, input mag_t c);
    mag_t m;
    m = (b > a) ? b : a;
    return (c > m) ? c : m;
  endfunction

  // index of the highest set bit, found byte first
  function automatic logic [5:0] msb_pos(input mag_t v);
    logic [2:0] grp;
    logic [2:0] bp;
    logic [7:0] byt;
    grp = '0;
    bp  = '0;
    for (int i = 0; i < MAG_W / 8; i++) begin
      if (|v[8*i +: 8]) grp = 3'(i);
    end
    byt = v[8*grp +: 8];
    for (int i = 0; i < 8; i++) begin
      if (byt[i]) bp = 3'(i);
    end
    return {grp, bp};
  endfunction

  // bring the bit at pos to bit FRAC_W-1, truncating on right shifts
  function automatic logic [FRAC_W-1:0] scale_mag(input mag_t m, input logic [5:0] pos);
    mag_t s;
    if (pos >= 6'(FRAC_W - 1)) s = m >> (pos - 6'(FRAC_W - 1));
    else s = m << (6'(FRAC_W - 1) - pos);
    return s[FRAC_W-1:0];
  endfunction

endpackage

// ===== design/lav_target_if.sv =====
// target point channel: valid/ready handshake with the target payload
interface lav_target_if import lav_pkg::*; ();
  logic    valid;
  logic    ready;
  target_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/lav_matrix_if.sv =====
// matrix result channel: valid/ready handshake with the view matrix payload
interface lav_matrix_if import lav_pkg::*; ();
  logic    valid;
  logic    ready;
  matrix_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/lav_unit3.sv =====
// pipelined 3-vector normalizer: scale, square sum, bit-serial sqrt, restoring divide
module lav_unit3 import lav_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  mag_t       mag_i [3],
  input  logic [2:0] neg_i,
  output logic       valid_o,
  output out_t       vec_o [3]
);

  typedef struct packed {
    logic [2:0][FRAC_W-1:0] m;
    logic [2:0]             neg;
    logic                   zero;
  } meta_t;

  // front stages
  logic                     v1_q, v2_q, v3_q, v4_q, v5_q;
  mag_t                     m1_q [3];
  mag_t                     m2_q [3];
  mag_t                     max1_q;
  logic [2:0]               n1_q, n2_q;
  logic                     z2_q;
  logic [5:0]               pos2_q;
  meta_t                    meta3_q, meta4_q, meta5_q;
  logic [2*FRAC_W-1:0]      sq4_q [3];
  logic [2*FRAC_W+1:0]      sum5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) m1_q[i] <= mag_i[i];
      n1_q   <= neg_i;
      max1_q <= max3(mag_i[0], mag_i[1], mag_i[2]);

      for (int i = 0; i < 3; i++) m2_q[i] <= m1_q[i];
      n2_q   <= n1_q;
      z2_q   <= (max1_q == '0);
      pos2_q <= msb_pos(max1_q);

      for (int i = 0; i < 3; i++) meta3_q.m[i] <= scale_mag(m2_q[i], pos2_q);
      meta3_q.neg  <= n2_q;
      meta3_q.zero <= z2_q;

      for (int i = 0; i < 3; i++) sq4_q[i] <= meta3_q.m[i] * meta3_q.m[i];
      meta4_q <= meta3_q;

      sum5_q  <= (2*FRAC_W+2)'(sq4_q[0]) + (2*FRAC_W+2)'(sq4_q[1])
               + (2*FRAC_W+2)'(sq4_q[2]);
      meta5_q <= meta4_q;
    end
  end

  // square root, one result bit per stage
  logic        sv_q [SQRT_STEPS];
  logic [63:0] sn_q [SQRT_STEPS];
  logic [63:0] sr_q [SQRT_STEPS];
  meta_t       sm_q [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic        v_in;
    logic [63:0] n_in, r_in, bitv, trial;
    meta_t       meta_in;

    if (k == 0) begin : g_first
      assign v_in    = v5_q;
      assign n_in    = 64'(sum5_q);
      assign r_in    = '0;
      assign meta_in = meta5_q;
    end else begin : g_next
      assign v_in    = sv_q[k-1];
      assign n_in    = sn_q[k-1];
      assign r_in    = sr_q[k-1];
      assign meta_in = sm_q[k-1];
    end

    assign bitv  = 64'(1) << (2 * (SQRT_STEPS - 1 - k));
    assign trial = r_in + bitv;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[k] <= 1'b0;
      else if (en_i) sv_q[k] <= v_in;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sm_q[k] <= meta_in;
        if (n_in >= trial) begin
          sn_q[k] <= n_in - trial;
          sr_q[k] <= (r_in >> 1) + bitv;
        end else begin
          sn_q[k] <= n_in;
          sr_q[k] <= r_in >> 1;
        end
      end
    end
  end

  // restoring divide, one quotient bit per stage, three lanes
  logic              dv_q [DIV_STEPS];
  logic [63:0]       drem_q [DIV_STEPS][3];
  logic [FRAC_W:0]   dq_q [DIV_STEPS][3];
  logic [31:0]       dl_q [DIV_STEPS];
  meta_t             dm_q [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic            v_in;
    logic [31:0]     l_in;
    logic [63:0]     rem_in [3];
    logic [FRAC_W:0] q_in [3];
    logic [63:0]     dsh;
    meta_t           meta_in;

    if (j == 0) begin : g_first
      assign v_in    = sv_q[SQRT_STEPS-1];
      assign l_in    = sr_q[SQRT_STEPS-1][31:0];
      assign meta_in = sm_q[SQRT_STEPS-1];
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_in[i] = (64'(meta_in.m[i]) << FRAC_W) + 64'(l_in >> 1);
        assign q_in[i]   = '0;
      end
    end else begin : g_next
      assign v_in    = dv_q[j-1];
      assign l_in    = dl_q[j-1];
      assign meta_in = dm_q[j-1];
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_in[i] = drem_q[j-1][i];
        assign q_in[i]   = dq_q[j-1][i];
      end
    end

    assign dsh = 64'(l_in) << (DIV_STEPS - 1 - j);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[j] <= 1'b0;
      else if (en_i) dv_q[j] <= v_in;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dl_q[j] <= l_in;
        dm_q[j] <= meta_in;
        for (int i = 0; i < 3; i++) begin
          if (rem_in[i] >= dsh) begin
            drem_q[j][i] <= rem_in[i] - dsh;
            dq_q[j][i]   <= q_in[i] | ((FRAC_W+1)'(1) << (DIV_STEPS - 1 - j));
          end else begin
            drem_q[j][i] <= rem_in[i];
            dq_q[j][i]   <= q_in[i];
          end
        end
      end
    end
  end

  // sign and zero-length override
  logic vf_q;
  out_t vec_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vf_q <= 1'b0;
    else if (en_i) vf_q <= dv_q[DIV_STEPS-1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        if (dm_q[DIV_STEPS-1].zero) vec_q[i] <= '0;
        else if (dm_q[DIV_STEPS-1].neg[i]) vec_q[i] <= -out_t'(dq_q[DIV_STEPS-1][i]);
        else vec_q[i] <= out_t'(dq_q[DIV_STEPS-1][i]);
      end
    end
  end

  assign valid_o = vf_q;
  for (genvar i = 0; i < 3; i++) begin : g_out
    assign vec_o[i] = vec_q[i];
  end

endmodule

// ===== design/look_at_view_matrix.sv =====
// Left-handed look-at view matrix pipeline. Each transfer on target_i carries one
// target point (signed Q16.16); the block answers with one transfer on matrix_o holding
// the unit right, camera up and forward vectors (signed Q2.30) and the three
// translations -(right.eye), -(camera_up.eye), -(forward.eye) (Q16.16, saturated).
// Eye position and world up come from six 32-bit registers on the APB port at byte
// addresses 0x00..0x14 (eye x/y/z, up x/y/z); reset gives eye (0,0,3) and up (0,1,0).
// A new target is taken every cycle unless matrix_o stalls; the pipeline depth, PIPE_DEPTH,
// comes mostly from the two normalize units, each a 32-step square root followed by
// a 31-step divider, one step per stage. A stall on matrix_o holds the whole pipeline.
// Registers may only be rewritten while no item is in flight.
module look_at_view_matrix import lav_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  lav_target_if.sink        target_i,
  lav_matrix_if.source      matrix_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  coord_t     cfg_q [NUM_REGS];
  logic [2:0] reg_idx;
  logic       reg_hit;

  assign reg_idx = paddr[4:2];
  assign reg_hit = (reg_idx < 3'(NUM_REGS));
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_q[i] <= REG_RESET[i];
    end else if (psel && penable && pwrite && reg_hit) begin
      cfg_q[reg_idx] <= pwdata;
    end
  end

  assign prdata = reg_hit ? 32'(cfg_q[reg_idx]) : '0;

  coord_t eye [3];
  assign eye[0] = cfg_q[REG_EYE_X];
  assign eye[1] = cfg_q[REG_EYE_Y];
  assign eye[2] = cfg_q[REG_EYE_Z];

  // global advance: the last stage is the output register, everything moves with it
  logic en;
  assign en             = !matrix_o.valid || matrix_o.ready;
  assign target_i.ready = en;

  // ---------------------------------------------------------------------------
  // world up scaling, free running off the registers (settles long before any item
  // reaches the right-vector cross product)
  // ---------------------------------------------------------------------------
  mag_t                     up1_m_q [3];
  mag_t                     up2_m_q [3];
  mag_t                     up2_max_q;
  logic [2:0]               up1_n_q, up2_n_q, up3_n_q;
  logic [2:0][FRAC_W-1:0]   up3_m_q;
  logic signed [FRAC_W:0]   upv_q [3];
  coord_t                   up_reg [3];

  assign up_reg[0] = cfg_q[REG_UP_X];
  assign up_reg[1] = cfg_q[REG_UP_Y];
  assign up_reg[2] = cfg_q[REG_UP_Z];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      up1_m_q[i] <= abs_mag((MAG_W+1)'(up_reg[i]));
      up1_n_q[i] <= up_reg[i][COORD_WIDTH-1];
      up2_m_q[i] <= up1_m_q[i];
    end
    up2_n_q   <= up1_n_q;
    up2_max_q <= max3(up1_m_q[0], up1_m_q[1], up1_m_q[2]);
    for (int i = 0; i < 3; i++) begin
      up3_m_q[i] <= scale_mag(up2_m_q[i], msb_pos(up2_max_q));
      upv_q[i]   <= up3_n_q[i] ? -(FRAC_W+1)'(up3_m_q[i]) : (FRAC_W+1)'(up3_m_q[i]);
    end
    up3_n_q <= up2_n_q;
  end

  // ---------------------------------------------------------------------------
  // view direction: target minus eye, as sign and magnitude
  // ---------------------------------------------------------------------------
  coord_t                      tgt [3];
  logic signed [COORD_WIDTH:0] diff [3];
  logic                        t1_valid_q;
  mag_t                        t1_mag_q [3];
  logic [2:0]                  t1_neg_q;

  assign tgt[0] = target_i.data.target_x;
  assign tgt[1] = target_i.data.target_y;
  assign tgt[2] = target_i.data.target_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = (COORD_WIDTH+1)'(tgt[i]) - (COORD_WIDTH+1)'(eye[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) t1_valid_q <= 1'b0;
    else if (en) t1_valid_q <= target_i.valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t1_mag_q[i] <= abs_mag((MAG_W+1)'(diff[i]));
        t1_neg_q[i] <= diff[i][COORD_WIDTH];
      end
    end
  end

  // forward = normalize(target - eye)
  logic fa_valid;
  out_t fwd [3];

  lav_unit3 u_fwd_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (t1_valid_q),
    .mag_i   (t1_mag_q),
    .neg_i   (t1_neg_q),
    .valid_o (fa_valid),
    .vec_o   (fwd)
  );

  // ---------------------------------------------------------------------------
  // up x forward: products, then differences as sign and magnitude
  // ---------------------------------------------------------------------------
  logic               c1_valid_q, c2_valid_q;
  logic signed [63:0] c1_p_q [6];
  out_t               c1_fwd_q [3];
  out_t               c2_fwd_q [3];
  mag_t               c2_mag_q [3];
  logic [2:0]         c2_neg_q;
  logic signed [63:0] rc [3];

  assign rc[0] = c1_p_q[0] - c1_p_q[1];
  assign rc[1] = c1_p_q[2] - c1_p_q[3];
  assign rc[2] = c1_p_q[4] - c1_p_q[5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_valid_q <= 1'b0;
      c2_valid_q <= 1'b0;
    end else if (en) begin
      c1_valid_q <= fa_valid;
      c2_valid_q <= c1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_p_q[0] <= upv_q[1] * fwd[2];
      c1_p_q[1] <= upv_q[2] * fwd[1];
      c1_p_q[2] <= upv_q[2] * fwd[0];
      c1_p_q[3] <= upv_q[0] * fwd[2];
      c1_p_q[4] <= upv_q[0] * fwd[1];
      c1_p_q[5] <= upv_q[1] * fwd[0];
      for (int i = 0; i < 3; i++) begin
        c1_fwd_q[i] <= fwd[i];
        c2_fwd_q[i] <= c1_fwd_q[i];
        c2_mag_q[i] <= abs_mag((MAG_W+1)'(rc[i]));
        c2_neg_q[i] <= rc[i][63];
      end
    end
  end

  // right = normalize(up x forward); forward rides alongside in a delay line
  logic rb_valid;
  out_t right [3];
  out_t fwd_dly_q [UNIT_LAT][3];

  lav_unit3 u_right_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c2_valid_q),
    .mag_i   (c2_mag_q),
    .neg_i   (c2_neg_q),
    .valid_o (rb_valid),
    .vec_o   (right)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        fwd_dly_q[0][i] <= c2_fwd_q[i];
        for (int k = 1; k < UNIT_LAT; k++) fwd_dly_q[k][i] <= fwd_dly_q[k-1][i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // camera up = forward x right, rounded half away from zero to Q2.30
  // ---------------------------------------------------------------------------
  logic               e1_valid_q, e2_valid_q, e3_valid_q;
  logic signed [63:0] e1_p_q [6];
  logic signed [63:0] e2_d_q [3];
  out_t               e1_fwd_q [3];
  out_t               e1_right_q [3];
  out_t               e2_fwd_q [3];
  out_t               e2_right_q [3];
  out_t               e3_fwd_q [3];
  out_t               e3_right_q [3];
  out_t               e3_cu_q [3];
  mag_t               cu_rnd [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cu_rnd[i] = (abs_mag((MAG_W+1)'(e2_d_q[i])) + (MAG_W'(1) << (FRAC_W - 1))) >> FRAC_W;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_valid_q <= 1'b0;
      e2_valid_q <= 1'b0;
      e3_valid_q <= 1'b0;
    end else if (en) begin
      e1_valid_q <= rb_valid;
      e2_valid_q <= e1_valid_q;
      e3_valid_q <= e2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_p_q[0] <= fwd_dly_q[UNIT_LAT-1][1] * right[2];
      e1_p_q[1] <= fwd_dly_q[UNIT_LAT-1][2] * right[1];
      e1_p_q[2] <= fwd_dly_q[UNIT_LAT-1][2] * right[0];
      e1_p_q[3] <= fwd_dly_q[UNIT_LAT-1][0] * right[2];
      e1_p_q[4] <= fwd_dly_q[UNIT_LAT-1][0] * right[1];
      e1_p_q[5] <= fwd_dly_q[UNIT_LAT-1][1] * right[0];
      e2_d_q[0] <= e1_p_q[0] - e1_p_q[1];
      e2_d_q[1] <= e1_p_q[2] - e1_p_q[3];
      e2_d_q[2] <= e1_p_q[4] - e1_p_q[5];
      for (int i = 0; i < 3; i++) begin
        e1_fwd_q[i]   <= fwd_dly_q[UNIT_LAT-1][i];
        e1_right_q[i] <= right[i];
        e2_fwd_q[i]   <= e1_fwd_q[i];
        e2_right_q[i] <= e1_right_q[i];
        e3_fwd_q[i]   <= e2_fwd_q[i];
        e3_right_q[i] <= e2_right_q[i];
        // saturate to the 32-bit range on either side
        if (e2_d_q[i][63]) begin
          if (cu_rnd[i] > (MAG_W'(1) << (OUT_W - 1))) e3_cu_q[i] <= {1'b1, {(OUT_W-1){1'b0}}};
          else e3_cu_q[i] <= out_t'(OUT_W'(-cu_rnd[i]));
        end else begin
          if (cu_rnd[i] > (MAG_W'(1) << (OUT_W - 1)) - 1) e3_cu_q[i] <= {1'b0, {(OUT_W-1){1'b1}}};
          else e3_cu_q[i] <= out_t'(OUT_W'(cu_rnd[i]));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // translations: -(basis . eye), rounded half up to Q16.16 and saturated
  // vector 0 is right, 1 camera up, 2 forward
  // ---------------------------------------------------------------------------
  localparam int ACC_W = 68;
  localparam int SH_W  = ACC_W - FRAC_W;
  localparam logic signed [SH_W-1:0] SAT_HI = (SH_W'(1) << (OUT_W - 1)) - SH_W'(1);
  localparam logic signed [SH_W-1:0] SAT_LO = -(SH_W'(1) << (OUT_W - 1));

  logic                    f1_valid_q, f2_valid_q, f3_valid_q;
  logic signed [63:0]      f1_p_q [3][3];
  logic signed [ACC_W-1:0] f2_acc_q [3];
  out_t                    f1_vec_q [3][3];
  out_t                    f2_vec_q [3][3];
  out_t                    f3_vec_q [3][3];
  out_t                    f3_sh_q [3];
  logic signed [SH_W-1:0]  sh [3];
  out_t                    basis [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      basis[0][i] = e3_right_q[i];
      basis[1][i] = e3_cu_q[i];
      basis[2][i] = e3_fwd_q[i];
      sh[i]       = SH_W'(f2_acc_q[i] >>> FRAC_W);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
      f3_valid_q <= 1'b0;
    end else if (en) begin
      f1_valid_q <= e3_valid_q;
      f2_valid_q <= f1_valid_q;
      f3_valid_q <= f2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int v = 0; v < 3; v++) begin
        for (int i = 0; i < 3; i++) begin
          f1_p_q[v][i]   <= basis[v][i] * eye[i];
          f1_vec_q[v][i] <= basis[v][i];
          f2_vec_q[v][i] <= f1_vec_q[v][i];
          f3_vec_q[v][i] <= f2_vec_q[v][i];
        end
        f2_acc_q[v] <= (ACC_W'(1) << (FRAC_W - 1))
                     - (ACC_W'(f1_p_q[v][0]) + ACC_W'(f1_p_q[v][1]) + ACC_W'(f1_p_q[v][2]));
        if (sh[v] > SAT_HI) f3_sh_q[v] <= {1'b0, {(OUT_W-1){1'b1}}};
        else if (sh[v] < SAT_LO) f3_sh_q[v] <= {1'b1, {(OUT_W-1){1'b0}}};
        else f3_sh_q[v] <= out_t'(OUT_W'(sh[v]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result channel
  // ---------------------------------------------------------------------------
  assign matrix_o.valid            = f3_valid_q;
  assign matrix_o.data.right_x     = f3_vec_q[0][0];
  assign matrix_o.data.right_y     = f3_vec_q[0][1];
  assign matrix_o.data.right_z     = f3_vec_q[0][2];
  assign matrix_o.data.camera_up_x = f3_vec_q[1][0];
  assign matrix_o.data.camera_up_y = f3_vec_q[1][1];
  assign matrix_o.data.camera_up_z = f3_vec_q[1][2];
  assign matrix_o.data.forward_x   = f3_vec_q[2][0];
  assign matrix_o.data.forward_y   = f3_vec_q[2][1];
  assign matrix_o.data.forward_z   = f3_vec_q[2][2];
  assign matrix_o.data.shift_x     = f3_sh_q[0];
  assign matrix_o.data.shift_y     = f3_sh_q[1];
  assign matrix_o.data.shift_z     = f3_sh_q[2];

endmodule

// ===== design/lav_checker.sv =====
// port-level checker for the look-at view matrix block and its bind
module lav_checker import lav_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input matrix_t           out_data,
  input logic              psel,
  input logic [ADDR_W-1:0] paddr,
  input logic [31:0]       prdata
);

  localparam int CNT_W = $clog2(PIPE_DEPTH + 1) + 1;

  logic [CNT_W-1:0] outstanding_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) outstanding_q <= '0;
    else outstanding_q <= outstanding_q + CNT_W'(in_valid && in_ready)
                        - CNT_W'(out_valid && out_ready);
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready |-> outstanding_q != '0)
    else $error("result transfer without a target");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outstanding_q <= CNT_W'(PIPE_DEPTH))
    else $error("more items in flight than pipeline stages");

  a_rd_unmapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && paddr[4:2] >= 3'(NUM_REGS) |-> prdata == '0)
    else $error("unmapped register read nonzero");

endmodule

bind look_at_view_matrix lav_checker u_lav_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (target_i.valid),
  .in_ready  (target_i.ready),
  .out_valid (matrix_o.valid),
  .out_ready (matrix_o.ready),
  .out_data  (matrix_o.data),
  .psel      (psel),
  .paddr     (paddr),
  .prdata    (prdata)
);

// ===== dv/tb_look_at_view_matrix.sv =====
// testbench for the look-at view matrix pipeline: targets in, predicted matrices checked out
module tb_look_at_view_matrix;
  import lav_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 600000;
  localparam logic signed [63:0] ONE_Q30 = 64'sd1 << 30;

  typedef logic signed [63:0] s64_t;
  typedef s64_t vec3_t [3];

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // apb side
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  lav_target_if target_ch ();
  lav_matrix_if matrix_ch ();

  look_at_view_matrix uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .target_i (target_ch.sink),
    .matrix_o (matrix_ch.source),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the camera registers, updated along with every apb write
  coord_t  cam_reg [NUM_REGS];
  matrix_t matrix_queue [$];
  int      fail_count = 0;
  int      cycle_count = 0;

  // knobs shared between the test tasks and the two driving processes
  bit sender_gaps = 1'b1;
  bit receiver_gaps = 1'b1;
  int receiver_hold = 0;

  // ---------------------------------------------------------------------------
  // matrix predictor
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // shift all magnitudes by one power of two so the largest sits in [2^29, 2^30)
  function automatic bit scale_to_q30(input vec3_t v, output vec3_t m);
    s64_t mx;
    for (int i = 0; i < 3; i++) m[i] = (v[i] < 0) ? -v[i] : v[i];
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    if (mx == 0) return 1'b0;
    while (mx >= ONE_Q30) begin
      mx = mx >>> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >>> 1;
    end
    while (mx < (ONE_Q30 >>> 1)) begin
      mx = mx <<< 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] <<< 1;
    end
    return 1'b1;
  endfunction

  function automatic void normalize(input vec3_t v, output vec3_t u);
    vec3_t m;
    logic [63:0] len;
    logic [63:0] q;
    if (!scale_to_q30(v, m)) begin
      u = '{64'sd0, 64'sd0, 64'sd0};
      return;
    end
    len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    for (int i = 0; i < 3; i++) begin
      q = ((64'(m[i]) << 30) + (len >> 1)) / len;
      u[i] = (v[i] < 0) ? -s64_t'(q) : s64_t'(q);
    end
  endfunction

  function automatic void cross3(input vec3_t a, input vec3_t b, output vec3_t c);
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  // -(basis . eye) in Q.46, rounded half up to Q16.16 and saturated
  function automatic out_t neg_dot_q16(input vec3_t basis);
    logic signed [127:0] acc;
    logic signed [127:0] q;
    acc = '0;
    for (int i = 0; i < 3; i++)
      acc = acc + 128'(signed'(cam_reg[i])) * 128'(basis[i]);
    acc = -acc + (128'sd1 <<< 29);
    q = acc >>> 30;
    if (q > 128'sh7FFF_FFFF) return out_t'(32'h7FFF_FFFF);
    if (q < -128'sh8000_0000) return out_t'(32'h8000_0000);
    return out_t'(q[31:0]);
  endfunction

  function automatic matrix_t predict_matrix(input target_t t);
    vec3_t   view, up, up_mag, fwd, rc, right, cam_up;
    s64_t    mag, q;
    matrix_t r;
    view[0] = s64_t'(t.target_x) - s64_t'(cam_reg[REG_EYE_X]);
    view[1] = s64_t'(t.target_y) - s64_t'(cam_reg[REG_EYE_Y]);
    view[2] = s64_t'(t.target_z) - s64_t'(cam_reg[REG_EYE_Z]);
    normalize(view, fwd);
    for (int i = 0; i < 3; i++) up[i] = s64_t'(cam_reg[3 + i]);
    if (scale_to_q30(up, up_mag)) begin
      for (int i = 0; i < 3; i++) up[i] = (up[i] < 0) ? -up_mag[i] : up_mag[i];
    end else begin
      up = '{64'sd0, 64'sd0, 64'sd0};
    end
    cross3(up, fwd, rc);
    normalize(rc, right);
    // camera up: round the Q4.60 cross product by magnitude, half away from zero
    cross3(fwd, right, rc);
    for (int i = 0; i < 3; i++) begin
      mag = (rc[i] < 0) ? -rc[i] : rc[i];
      q = (mag + (ONE_Q30 >>> 1)) >>> 30;
      if (rc[i] < 0) cam_up[i] = (q > 64'sh8000_0000) ? -64'sh8000_0000 : -q;
      else cam_up[i] = (q > 64'sh7FFF_FFFF) ? 64'sh7FFF_FFFF : q;
    end
    r.right_x     = out_t'(right[0]);
    r.right_y     = out_t'(right[1]);
    r.right_z     = out_t'(right[2]);
    r.camera_up_x = out_t'(cam_up[0]);
    r.camera_up_y = out_t'(cam_up[1]);
    r.camera_up_z = out_t'(cam_up[2]);
    r.forward_x   = out_t'(fwd[0]);
    r.forward_y   = out_t'(fwd[1]);
    r.forward_z   = out_t'(fwd[2]);
    r.shift_x     = neg_dot_q16(right);
    r.shift_y     = neg_dot_q16(cam_up);
    r.shift_z     = neg_dot_q16(fwd);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking: each matrix transfer against the oldest prediction
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input out_t want, input out_t got);
    if (want !== got) begin
      fail_count++;
      $display("%0t mismatch %s expected %0d (%h) actual %0d (%h)",
               $time, name, want, want, got, got);
    end
  endfunction

  always @(posedge clk_i) begin
    matrix_t want;
    matrix_t got;
    cycle_count <= cycle_count + 1;
    if (rst_ni && matrix_ch.valid && matrix_ch.ready) begin
      got = matrix_ch.data;
      if (matrix_queue.size() == 0) begin
        fail_count++;
        $display("%0t unexpected matrix transfer, expected none, actual %h", $time, got);
      end else begin
        want = matrix_queue.pop_front();
        check_field("right_x", want.right_x, got.right_x);
        check_field("right_y", want.right_y, got.right_y);
        check_field("right_z", want.right_z, got.right_z);
        check_field("camera_up_x", want.camera_up_x, got.camera_up_x);
        check_field("camera_up_y", want.camera_up_y, got.camera_up_y);
        check_field("camera_up_z", want.camera_up_z, got.camera_up_z);
        check_field("forward_x", want.forward_x, got.forward_x);
        check_field("forward_y", want.forward_y, got.forward_y);
        check_field("forward_z", want.forward_z, got.forward_z);
        check_field("shift_x", want.shift_x, got.shift_x);
        check_field("shift_y", want.shift_y, got.shift_y);
        check_field("shift_z", want.shift_z, got.shift_z);
      end
    end
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAIL look_at_view_matrix");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stall bursts, plus a long hold-off counted down here
  // ---------------------------------------------------------------------------

  initial begin
    int stall_left;
    stall_left = 0;
    matrix_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (receiver_hold > 0) begin
        matrix_ch.ready <= 1'b0;
        receiver_hold = receiver_hold - 1;
      end else if (!receiver_gaps) begin
        matrix_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        matrix_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        matrix_ch.ready <= 1'b1;
        if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 19);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender and register access
  // ---------------------------------------------------------------------------

  // offers one target, returns at the rising edge of its transfer
  task automatic send_target(input coord_t tx, input coord_t ty, input coord_t tz);
    target_t t;
    t.target_x = tx;
    t.target_y = ty;
    t.target_z = tz;
    @(negedge clk_i);
    if (sender_gaps && $urandom_range(0, 7) == 0) begin
      target_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    target_ch.valid <= 1'b1;
    target_ch.data  <= t;
    do @(posedge clk_i); while (!target_ch.ready);
    matrix_queue.push_back(predict_matrix(t));
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    target_ch.valid <= 1'b0;
  endtask

  // every target yields one matrix, so an empty queue means the pipe is empty
  task automatic wait_drained();
    stop_sending();
    wait (matrix_queue.size() == 0);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input coord_t value);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_W'(4 * idx);
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    cam_reg[idx] = value;
    // read it back over the same port
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== value) begin
      fail_count++;
      $display("%0t register %0d readback expected %h actual %h", $time, idx, value, prdata);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_camera(input coord_t ex, input coord_t ey, input coord_t ez,
                            input coord_t ux, input coord_t uy, input coord_t uz);
    wait_drained();
    write_reg(REG_EYE_X, ex);
    write_reg(REG_EYE_Y, ey);
    write_reg(REG_EYE_Z, ez);
    write_reg(REG_UP_X, ux);
    write_reg(REG_UP_Y, uy);
    write_reg(REG_UP_Z, uz);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
      1: return coord_t'($signed($urandom_range(0, 2000)) - 1000);
      2: return coord_t'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // about as many targets near the eye as far away, and a few on the eye itself
  task automatic send_random_target();
    coord_t t [3];
    int kind;
    kind = $urandom_range(0, 19);
    for (int i = 0; i < 3; i++) begin
      if (kind == 0) t[i] = cam_reg[i];
      else if (kind < 10) t[i] = cam_reg[i] + coord_t'($signed($urandom_range(0, 32'h0004_0000))
                                                      - 32'sh0002_0000);
      else t[i] = rand_coord();
    end
    send_target(t[0], t[1], t[2]);
  endtask

  task automatic random_camera();
    coord_t u [3];
    int kind;
    kind = $urandom_range(0, 3);
    for (int i = 0; i < 3; i++) u[i] = rand_coord();
    if (kind == 0) begin
      u = '{coord_t'(0), coord_t'(0), coord_t'(0)};
      u[$urandom_range(0, 2)] = coord_t'($urandom_range(0, 1) ? 65536 : -65536);
    end
    set_camera(rand_coord(), rand_coord(), rand_coord(), u[0], u[1], u[2]);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset camera: eye at z = 3, up along y
  task automatic test_reset_camera();
    send_target(0, 0, 0);
    send_target(0, 0, 196608);                       // target on the eye
    send_target(0, 65536, 196608);                   // view parallel to up
    send_target(coord_t'(32'h7FFF_FFFF), coord_t'(32'h7FFF_FFFF), coord_t'(32'h7FFF_FFFF));
    send_target(coord_t'(32'h8000_0000), coord_t'(32'h8000_0000), coord_t'(32'h8000_0000));
    send_target(coord_t'(32'h7FFF_FFFF), coord_t'(32'h8000_0000), 1);
    send_target(1, -1, 196607);                      // tiny view vector
  endtask

  task automatic test_camera_extremes();
    // eye at the corners, targets at the opposite corner, other corners and the eye, shifts saturate
    set_camera(coord_t'(32'h8000_0000), coord_t'(32'h8000_0000), coord_t'(32'h8000_0000),
               coord_t'(32'h7FFF_FFFF), coord_t'(32'h7FFF_FFFF), coord_t'(32'h7FFF_FFFF));
    send_target(coord_t'(32'h7FFF_FFFF), coord_t'(32'h7FFF_FFFF), coord_t'(32'h7FFF_FFFF));
    send_target(coord_t'(32'h7FFF_FFFF), coord_t'(32'h8000_0000), coord_t'(32'h7FFF_FFFF));
    send_target(coord_t'(32'h8000_0000), coord_t'(32'h8000_0000), coord_t'(32'h8000_0000));
    set_camera(coord_t'(32'h7FFF_FFFF), coord_t'(32'h8000_0000), coord_t'(32'h7FFF_FFFF),
               coord_t'(32'h8000_0000), 0, coord_t'(32'h8000_0000));
    send_target(coord_t'(32'h8000_0000), coord_t'(32'h7FFF_FFFF), coord_t'(32'h8000_0000));
    send_target(0, 0, 0);
    // zero up vector
    set_camera(65536, -65536, 0, 0, 0, 0);
    send_target(0, 0, 0);
    send_target(65536, -65536, 0);
    // tiny up vector, scaled up before the cross product
    set_camera(0, 0, 0, 1, 0, -1);
    send_target(0, 65536, 0);
    send_target(0, 0, 65536);
    send_target(-1, -1, -1);
  endtask

  task automatic test_random_cameras(input int settings, input int per_setting);
    for (int s = 0; s < settings; s++) begin
      random_camera();
      for (int n = 0; n < per_setting; n++) send_random_target();
    end
  endtask

  // receiver holds off long enough for the pipe to fill and stall the input
  task automatic test_backpressure();
    receiver_hold = 400;
    for (int n = 0; n < 250; n++) send_random_target();
  endtask

  // sender stops until every matrix is back, then resumes
  task automatic test_drain_pause();
    for (int n = 0; n < 40; n++) send_random_target();
    wait_drained();
    for (int n = 0; n < 40; n++) send_random_target();
  endtask

  task automatic test_streaming();
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    random_camera();
    for (int n = 0; n < 200; n++) send_random_target();
  endtask

  initial begin
    for (int i = 0; i < NUM_REGS; i++) cam_reg[i] = REG_RESET[i];
    target_ch.valid = 1'b0;
    target_ch.data  = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_camera();
    test_camera_extremes();
    test_random_cameras(12, 50);
    test_backpressure();
    test_drain_pause();
    test_random_cameras(6, 60);
    test_streaming();

    stop_sending();
    wait (matrix_queue.size() == 0);
    repeat (PIPE_DEPTH + 20) @(posedge clk_i);
    if (fail_count == 0 && matrix_queue.size() == 0) begin
      $display("PASS look_at_view_matrix");
    end else begin
      $display("FAIL look_at_view_matrix");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/lav_pkg.sv
design/lav_target_if.sv
design/lav_matrix_if.sv
design/lav_unit3.sv
design/look_at_view_matrix.sv
design/lav_checker.sv
dv/tb_look_at_view_matrix.sv
